### hw/rtl/mbrk_pkg.sv
package mbrk_pkg;

  localparam int WordW = 32;
  localparam int FracW = 24;
  localparam int ProdW = 2 * WordW;
  localparam int NumK  = 4;

  typedef logic signed [WordW-1:0] word_t;
  typedef logic signed [ProdW-1:0] prod_t;

  localparam word_t MaxW = word_t'({1'b0, {(WordW-1){1'b1}}});
  localparam word_t MinW = word_t'({1'b1, {(WordW-1){1'b0}}});
  localparam logic [ProdW-1:0] HalfLsb = ProdW'(1) << (FracW - 1);

  // floor(x / 6) for any 32-bit x as (x * Div6Mul) >> Div6Shift
  localparam logic [31:0] Div6Mul   = 32'hAAAA_AAAB;
  localparam int          Div6Shift = 34;

  typedef enum logic [2:0] {
    RegTimeStep  = 3'd0,
    RegSpaceStep = 3'd1,
    RegInvDecay  = 3'd2,
    RegPolDecay  = 3'd3,
    RegFieldLoss = 3'd4,
    RegGain      = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    word_t re;
    word_t im;
  } cplx_t;

  typedef struct packed {
    word_t field_re;
    word_t field_im;
    word_t polar_re;
    word_t polar_im;
    word_t invers_re;
    word_t invers_im;
  } in_beat_t;

  typedef struct packed {
    word_t next_field_re;
    word_t next_field_im;
    word_t next_polar_re;
    word_t next_polar_im;
    word_t next_invers_re;
    word_t next_invers_im;
    logic  saturated;
  } out_beat_t;

  // coefficients shared by every k stage
  typedef struct packed {
    word_t gain;
    word_t loss;
    word_t rate_n;
    word_t rate_p;
  } cfg_t;

  // one cell on its way down the pipe
  typedef struct packed {
    cplx_t            e;
    cplx_t            p;
    cplx_t            n;
    cplx_t [NumK-1:0] ke;
    cplx_t [NumK-1:0] kn;
    cplx_t [NumK-1:0] kp;
    logic             sat;
  } cell_t;

  typedef struct packed {
    word_t v;
    logic  s;
  } sres_t;

  function automatic sres_t sat_add(word_t a, word_t b);
    logic signed [WordW:0] sum;
    sres_t r;
    sum = {a[WordW-1], a} + {b[WordW-1], b};
    if (sum[WordW] != sum[WordW-1]) begin
      r.s = 1'b1;
      r.v = sum[WordW] ? MinW : MaxW;
    end else begin
      r.s = 1'b0;
      r.v = sum[WordW-1:0];
    end
    return r;
  endfunction

  function automatic sres_t sat_sub(word_t a, word_t b);
    logic signed [WordW:0] dif;
    sres_t r;
    dif = {a[WordW-1], a} - {b[WordW-1], b};
    if (dif[WordW] != dif[WordW-1]) begin
      r.s = 1'b1;
      r.v = dif[WordW] ? MinW : MaxW;
    end else begin
      r.s = 1'b0;
      r.v = dif[WordW-1:0];
    end
    return r;
  endfunction

  function automatic prod_t raw_mul(word_t a, word_t b);
    prod_t pa;
    prod_t pb;
    pa = a;
    pb = b;
    return pa * pb;
  endfunction

  // round to nearest, ties away from zero, then clamp to the word
  function automatic sres_t round_mul(prod_t p);
    logic             neg;
    logic [ProdW-1:0] mag;
    logic [ProdW-1:0] q;
    logic [ProdW-1:0] lim;
    sres_t            r;
    neg = p[ProdW-1];
    mag = neg ? ProdW'(-p) : ProdW'(p);
    q   = (mag + HalfLsb) >> FracW;
    lim = {{WordW{1'b0}}, MaxW} + ProdW'(neg);
    if (q > lim) begin
      r.s = 1'b1;
      r.v = neg ? MinW : MaxW;
    end else begin
      r.s = 1'b0;
      r.v = neg ? -word_t'(q[WordW-1:0]) : word_t'(q[WordW-1:0]);
    end
    return r;
  endfunction

endpackage

### hw/rtl/mbrk_kstage.sv
module mbrk_kstage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [1:0]           idx_i,
  input  mbrk_pkg::word_t      hz_i,
  input  mbrk_pkg::word_t      ht_i,
  input  mbrk_pkg::cfg_t       cfg_i,
  input  logic                 valid_i,
  input  mbrk_pkg::cell_t      cell_i,
  output logic                 valid_o,
  output mbrk_pkg::cell_t      cell_o
);

  typedef struct packed {
    mbrk_pkg::prod_t gpi, gpr, ler, lei;
    mbrk_pkg::prod_t pe1, pe2, rnr, rni;
    mbrk_pkg::prod_t a1, a2, b1, b2, rpr, rpi;
  } mul_t;

  typedef struct packed {
    mbrk_pkg::word_t t, rnr, rni, a, b, rpr, rpi;
  } part_t;

  logic [4:0] v_q;

  // stage 1: raw increment products
  mbrk_pkg::cell_t   c1_q;
  mbrk_pkg::prod_t [5:0] inc_q, inc_d;
  mbrk_pkg::cplx_t   kpe, kpn, kpp;

  always_comb begin
    if (idx_i == 2'd0) begin
      kpe = '0;
      kpn = '0;
      kpp = '0;
    end else begin
      kpe = cell_i.ke[idx_i - 2'd1];
      kpn = cell_i.kn[idx_i - 2'd1];
      kpp = cell_i.kp[idx_i - 2'd1];
    end
    inc_d[0] = mbrk_pkg::raw_mul(hz_i, kpe.re);
    inc_d[1] = mbrk_pkg::raw_mul(hz_i, kpe.im);
    inc_d[2] = mbrk_pkg::raw_mul(ht_i, kpn.re);
    inc_d[3] = mbrk_pkg::raw_mul(ht_i, kpn.im);
    inc_d[4] = mbrk_pkg::raw_mul(ht_i, kpp.re);
    inc_d[5] = mbrk_pkg::raw_mul(ht_i, kpp.im);
  end

  // stage 2: round increments and offset the state
  mbrk_pkg::cell_t c2_q, c2_d;
  mbrk_pkg::cplx_t eo_q, po_q, no_q, eo_d, po_d, no_d;

  always_comb begin
    mbrk_pkg::sres_t r [6];
    mbrk_pkg::sres_t s [6];
    for (int i = 0; i < 6; i++) begin
      r[i] = mbrk_pkg::round_mul(inc_q[i]);
    end
    s[0] = mbrk_pkg::sat_add(c1_q.e.re, r[0].v);
    s[1] = mbrk_pkg::sat_add(c1_q.e.im, r[1].v);
    s[2] = mbrk_pkg::sat_add(c1_q.n.re, r[2].v);
    s[3] = mbrk_pkg::sat_add(c1_q.n.im, r[3].v);
    s[4] = mbrk_pkg::sat_add(c1_q.p.re, r[4].v);
    s[5] = mbrk_pkg::sat_add(c1_q.p.im, r[5].v);
    c2_d = c1_q;
    for (int i = 0; i < 6; i++) begin
      c2_d.sat = c2_d.sat | r[i].s | s[i].s;
    end
    eo_d.re = s[0].v;
    eo_d.im = s[1].v;
    no_d.re = s[2].v;
    no_d.im = s[3].v;
    po_d.re = s[4].v;
    po_d.im = s[5].v;
  end

  // stage 3: raw products of the derivative terms
  mbrk_pkg::cell_t c3_q;
  mul_t            m_q, m_d;

  always_comb begin
    m_d.gpi = mbrk_pkg::raw_mul(cfg_i.gain, c2_q.p.im);
    m_d.gpr = mbrk_pkg::raw_mul(cfg_i.gain, c2_q.p.re);
    m_d.ler = mbrk_pkg::raw_mul(cfg_i.loss, eo_q.re);
    m_d.lei = mbrk_pkg::raw_mul(cfg_i.loss, eo_q.im);
    m_d.pe1 = mbrk_pkg::raw_mul(po_q.re, c2_q.e.im);
    m_d.pe2 = mbrk_pkg::raw_mul(po_q.im, c2_q.e.re);
    m_d.rnr = mbrk_pkg::raw_mul(cfg_i.rate_n, no_q.re);
    m_d.rni = mbrk_pkg::raw_mul(cfg_i.rate_n, no_q.im);
    m_d.a1  = mbrk_pkg::raw_mul(c2_q.e.re, no_q.im);
    m_d.a2  = mbrk_pkg::raw_mul(c2_q.e.im, no_q.re);
    m_d.b1  = mbrk_pkg::raw_mul(c2_q.e.re, no_q.re);
    m_d.b2  = mbrk_pkg::raw_mul(c2_q.e.im, no_q.im);
    m_d.rpr = mbrk_pkg::raw_mul(cfg_i.rate_p, po_q.re);
    m_d.rpi = mbrk_pkg::raw_mul(cfg_i.rate_p, po_q.im);
  end

  // stage 4: round, first level of sums, field derivative done
  mbrk_pkg::cell_t c4_q, c4_d;
  mbrk_pkg::cplx_t ke_q, ke_d;
  part_t           pt_q, pt_d;

  always_comb begin
    mbrk_pkg::sres_t r_gpi, r_gpr, r_ler, r_lei, r_pe1, r_pe2, r_rnr, r_rni;
    mbrk_pkg::sres_t r_a1, r_a2, r_b1, r_b2, r_rpr, r_rpi;
    mbrk_pkg::sres_t fre, fim, t, a, b;
    r_gpi = mbrk_pkg::round_mul(m_q.gpi);
    r_gpr = mbrk_pkg::round_mul(m_q.gpr);
    r_ler = mbrk_pkg::round_mul(m_q.ler);
    r_lei = mbrk_pkg::round_mul(m_q.lei);
    r_pe1 = mbrk_pkg::round_mul(m_q.pe1);
    r_pe2 = mbrk_pkg::round_mul(m_q.pe2);
    r_rnr = mbrk_pkg::round_mul(m_q.rnr);
    r_rni = mbrk_pkg::round_mul(m_q.rni);
    r_a1  = mbrk_pkg::round_mul(m_q.a1);
    r_a2  = mbrk_pkg::round_mul(m_q.a2);
    r_b1  = mbrk_pkg::round_mul(m_q.b1);
    r_b2  = mbrk_pkg::round_mul(m_q.b2);
    r_rpr = mbrk_pkg::round_mul(m_q.rpr);
    r_rpi = mbrk_pkg::round_mul(m_q.rpi);
    fre = mbrk_pkg::sat_sub(r_gpi.v, r_ler.v);
    fim = mbrk_pkg::sat_sub(r_gpr.v, r_lei.v);
    t   = mbrk_pkg::sat_add(r_pe1.v, r_pe2.v);
    a   = mbrk_pkg::sat_sub(r_a1.v, r_a2.v);
    b   = mbrk_pkg::sat_add(r_b1.v, r_b2.v);
    ke_d.re = fre.v;
    ke_d.im = fim.v;
    pt_d.t   = t.v;
    pt_d.a   = a.v;
    pt_d.b   = b.v;
    pt_d.rnr = r_rnr.v;
    pt_d.rni = r_rni.v;
    pt_d.rpr = r_rpr.v;
    pt_d.rpi = r_rpi.v;
    c4_d = c3_q;
    c4_d.sat = c3_q.sat | r_gpi.s | r_gpr.s | r_ler.s | r_lei.s | r_pe1.s | r_pe2.s
             | r_rnr.s | r_rni.s | r_a1.s | r_a2.s | r_b1.s | r_b2.s | r_rpr.s
             | r_rpi.s | fre.s | fim.s | t.s | a.s | b.s;
  end

  // stage 5: doublings and final differences
  mbrk_pkg::cell_t c5_q, c5_d;

  always_comb begin
    mbrk_pkg::sres_t dt, da, db, nt, na, knr, kni, kpr, kpi;
    dt  = mbrk_pkg::sat_add(pt_q.t, pt_q.t);
    da  = mbrk_pkg::sat_add(pt_q.a, pt_q.a);
    db  = mbrk_pkg::sat_add(pt_q.b, pt_q.b);
    nt  = mbrk_pkg::sat_sub('0, dt.v);
    na  = mbrk_pkg::sat_sub('0, da.v);
    knr = mbrk_pkg::sat_sub(nt.v, pt_q.rnr);
    kni = mbrk_pkg::sat_sub('0, pt_q.rni);
    kpr = mbrk_pkg::sat_sub(na.v, pt_q.rpr);
    kpi = mbrk_pkg::sat_sub(db.v, pt_q.rpi);
    c5_d = c4_q;
    c5_d.ke[idx_i]    = ke_q;
    c5_d.kn[idx_i].re = knr.v;
    c5_d.kn[idx_i].im = kni.v;
    c5_d.kp[idx_i].re = kpr.v;
    c5_d.kp[idx_i].im = kpi.v;
    c5_d.sat = c4_q.sat | dt.s | da.s | db.s | nt.s | na.s | knr.s | kni.s | kpr.s
             | kpi.s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q  <= cell_i;
      inc_q <= inc_d;
      c2_q  <= c2_d;
      eo_q  <= eo_d;
      po_q  <= po_d;
      no_q  <= no_d;
      c3_q  <= c2_q;
      m_q   <= m_d;
      c4_q  <= c4_d;
      ke_q  <= ke_d;
      pt_q  <= pt_d;
      c5_q  <= c5_d;
    end
  end

  assign valid_o = v_q[4];
  assign cell_o  = c5_q;

endmodule

### hw/rtl/mbrk_sum.sv
module mbrk_sum (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  mbrk_pkg::word_t      hz6_i,
  input  mbrk_pkg::word_t      ht6_i,
  input  logic                 valid_i,
  input  mbrk_pkg::cell_t      cell_i,
  output logic                 valid_o,
  output mbrk_pkg::out_beat_t  beat_o
);

  // lanes: field re/im, polarization re/im, inversion re/im
  localparam int Lanes = 6;

  logic [3:0] v_q;

  mbrk_pkg::word_t [Lanes-1:0] x0, k1, k2, k3, k4;

  always_comb begin
    x0[0] = cell_i.e.re;      x0[1] = cell_i.e.im;
    x0[2] = cell_i.p.re;      x0[3] = cell_i.p.im;
    x0[4] = cell_i.n.re;      x0[5] = cell_i.n.im;
    k1[0] = cell_i.ke[0].re;  k1[1] = cell_i.ke[0].im;
    k1[2] = cell_i.kp[0].re;  k1[3] = cell_i.kp[0].im;
    k1[4] = cell_i.kn[0].re;  k1[5] = cell_i.kn[0].im;
    k2[0] = cell_i.ke[1].re;  k2[1] = cell_i.ke[1].im;
    k2[2] = cell_i.kp[1].re;  k2[3] = cell_i.kp[1].im;
    k2[4] = cell_i.kn[1].re;  k2[5] = cell_i.kn[1].im;
    k3[0] = cell_i.ke[2].re;  k3[1] = cell_i.ke[2].im;
    k3[2] = cell_i.kp[2].re;  k3[3] = cell_i.kp[2].im;
    k3[4] = cell_i.kn[2].re;  k3[5] = cell_i.kn[2].im;
    k4[0] = cell_i.ke[3].re;  k4[1] = cell_i.ke[3].im;
    k4[2] = cell_i.kp[3].re;  k4[3] = cell_i.kp[3].im;
    k4[4] = cell_i.kn[3].re;  k4[5] = cell_i.kn[3].im;
  end

  // stage 1: k1 + 2*k2, 2*k3
  mbrk_pkg::word_t [Lanes-1:0] x1_q, a1_q, d3_q, k4_1_q, a1_d, d3_d;
  logic                        s1_q, s1_d;

  always_comb begin
    mbrk_pkg::sres_t d2, ad, d3;
    s1_d = cell_i.sat;
    for (int i = 0; i < Lanes; i++) begin
      d2 = mbrk_pkg::sat_add(k2[i], k2[i]);
      ad = mbrk_pkg::sat_add(k1[i], d2.v);
      d3 = mbrk_pkg::sat_add(k3[i], k3[i]);
      a1_d[i] = ad.v;
      d3_d[i] = d3.v;
      s1_d = s1_d | d2.s | ad.s | d3.s;
    end
  end

  // stage 2: + 2*k3 + k4
  mbrk_pkg::word_t [Lanes-1:0] x2_q, b2_q, b2_d;
  logic                        s2_q, s2_d;

  always_comb begin
    mbrk_pkg::sres_t u, w;
    s2_d = s1_q;
    for (int i = 0; i < Lanes; i++) begin
      u = mbrk_pkg::sat_add(a1_q[i], d3_q[i]);
      w = mbrk_pkg::sat_add(u.v, k4_1_q[i]);
      b2_d[i] = w.v;
      s2_d = s2_d | u.s | w.s;
    end
  end

  // stage 3: raw product with h/6
  mbrk_pkg::word_t [Lanes-1:0] x3_q;
  mbrk_pkg::prod_t [Lanes-1:0] m3_q, m3_d;
  logic                        s3_q;

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      m3_d[i] = mbrk_pkg::raw_mul((i < 2) ? hz6_i : ht6_i, b2_q[i]);
    end
  end

  // stage 4: round and add to the state
  mbrk_pkg::word_t [Lanes-1:0] y4_q, y4_d;
  logic                        s4_q, s4_d;

  always_comb begin
    mbrk_pkg::sres_t r, y;
    s4_d = s3_q;
    for (int i = 0; i < Lanes; i++) begin
      r = mbrk_pkg::round_mul(m3_q[i]);
      y = mbrk_pkg::sat_add(x3_q[i], r.v);
      y4_d[i] = y.v;
      s4_d = s4_d | r.s | y.s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q   <= x0;
      a1_q   <= a1_d;
      d3_q   <= d3_d;
      k4_1_q <= k4;
      s1_q   <= s1_d;
      x2_q   <= x1_q;
      b2_q   <= b2_d;
      s2_q   <= s2_d;
      x3_q   <= x2_q;
      m3_q   <= m3_d;
      s3_q   <= s2_q;
      y4_q   <= y4_d;
      s4_q   <= s4_d;
    end
  end

  assign valid_o = v_q[3];

  always_comb begin
    beat_o.next_field_re  = y4_q[0];
    beat_o.next_field_im  = y4_q[1];
    beat_o.next_polar_re  = y4_q[2];
    beat_o.next_polar_im  = y4_q[3];
    beat_o.next_invers_re = y4_q[4];
    beat_o.next_invers_im = y4_q[5];
    beat_o.saturated      = s4_q;
  end

endmodule

### hw/rtl/maxwell_bloch_rk4_cell_step_top.sv
// maxwell-bloch cell step: takes one grid cell (field E, polarization P,
// inversion N, all complex Q8.24) per beat and returns E advanced one space
// step and N, P advanced one time step by fourth-order runge-kutta, with a
// sticky-per-beat flag when any intermediate saturated. fully pipelined: one
// cell per clock sustained while the output is taken; a beat passes four k
// stages of five registers each, a four-register weighted sum and one output
// register. the pipe advances as a whole whenever the output register is
// empty or being taken, so in_ready_o only drops while a finished beat waits.
// coefficients sit in apb registers at byte addresses 0x00..0x14; h/6 is
// registered from the step registers in the cycle after a write, so write
// only while no cell is in flight.
module maxwell_bloch_rk4_cell_step_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input beats
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mbrk_pkg::in_beat_t   in_beat_i,
  // output beats
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mbrk_pkg::out_beat_t  out_beat_o,
  // apb register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // configuration registers
  logic [30:0]     ts_q, hs_q, rn_q, rp_q, loss_q;
  mbrk_pkg::word_t g_q;
  mbrk_pkg::word_t ht6_q, hz6_q, ht6_d, hz6_d;

  logic                  wr_en;
  mbrk_pkg::cfg_reg_e    reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = mbrk_pkg::cfg_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q   <= 31'd16777216;
      hs_q   <= 31'd16777;
      rn_q   <= 31'd17;
      rp_q   <= 31'd17;
      loss_q <= 31'd0;
      g_q    <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        mbrk_pkg::RegTimeStep:  ts_q   <= pwdata[30:0];
        mbrk_pkg::RegSpaceStep: hs_q   <= pwdata[30:0];
        mbrk_pkg::RegInvDecay:  rn_q   <= pwdata[30:0];
        mbrk_pkg::RegPolDecay:  rp_q   <= pwdata[30:0];
        mbrk_pkg::RegFieldLoss: loss_q <= pwdata[30:0];
        mbrk_pkg::RegGain:      g_q    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      mbrk_pkg::RegTimeStep:  prdata = {1'b0, ts_q};
      mbrk_pkg::RegSpaceStep: prdata = {1'b0, hs_q};
      mbrk_pkg::RegInvDecay:  prdata = {1'b0, rn_q};
      mbrk_pkg::RegPolDecay:  prdata = {1'b0, rp_q};
      mbrk_pkg::RegFieldLoss: prdata = {1'b0, loss_q};
      mbrk_pkg::RegGain:      prdata = g_q;
      default:                prdata = '0;
    endcase
  end

  // h/6 rounded as (h + 3) / 6, by reciprocal multiply
  logic [31:0] ht_p3, hz_p3;
  logic [63:0] ht_div, hz_div;

  always_comb begin
    ht_p3  = {1'b0, ts_q} + 32'd3;
    hz_p3  = {1'b0, hs_q} + 32'd3;
    ht_div = (64'(ht_p3) * 64'(mbrk_pkg::Div6Mul)) >> mbrk_pkg::Div6Shift;
    hz_div = (64'(hz_p3) * 64'(mbrk_pkg::Div6Mul)) >> mbrk_pkg::Div6Shift;
    ht6_d  = mbrk_pkg::word_t'(ht_div[31:0]);
    hz6_d  = mbrk_pkg::word_t'(hz_div[31:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ht6_q <= 32'sd2796203;
      hz6_q <= 32'sd2796;
    end else begin
      ht6_q <= ht6_d;
      hz6_q <= hz6_d;
    end
  end

  // h and h/2 as words, h/2 rounded up
  logic [31:0]     ht_p1, hz_p1;
  mbrk_pkg::word_t ht_w, hz_w, ht2_w, hz2_w;
  mbrk_pkg::cfg_t  cfg;

  always_comb begin
    ht_p1      = {1'b0, ts_q} + 32'd1;
    hz_p1      = {1'b0, hs_q} + 32'd1;
    ht_w       = mbrk_pkg::word_t'({1'b0, ts_q});
    hz_w       = mbrk_pkg::word_t'({1'b0, hs_q});
    ht2_w      = mbrk_pkg::word_t'({1'b0, ht_p1[31:1]});
    hz2_w      = mbrk_pkg::word_t'({1'b0, hz_p1[31:1]});
    cfg.gain   = g_q;
    cfg.loss   = mbrk_pkg::word_t'({1'b0, loss_q});
    cfg.rate_n = mbrk_pkg::word_t'({1'b0, rn_q});
    cfg.rate_p = mbrk_pkg::word_t'({1'b0, rp_q});
  end

  // pipe advances when the output register is free or drains this cycle
  logic pipe_en;
  logic out_valid_q;

  assign pipe_en    = ~out_valid_q | out_ready_i;
  assign in_ready_o = pipe_en;

  mbrk_pkg::cell_t cell_in;

  always_comb begin
    cell_in      = '0;
    cell_in.e.re = in_beat_i.field_re;
    cell_in.e.im = in_beat_i.field_im;
    cell_in.p.re = in_beat_i.polar_re;
    cell_in.p.im = in_beat_i.polar_im;
    cell_in.n.re = in_beat_i.invers_re;
    cell_in.n.im = in_beat_i.invers_im;
  end

  // k1..k4 chain: k1 uses zero increments, k2/k3 half steps, k4 full step
  logic            kv   [mbrk_pkg::NumK+1];
  mbrk_pkg::cell_t kc   [mbrk_pkg::NumK+1];
  mbrk_pkg::word_t hz_k [mbrk_pkg::NumK];
  mbrk_pkg::word_t ht_k [mbrk_pkg::NumK];

  assign kv[0]   = in_valid_i;
  assign kc[0]   = cell_in;
  assign hz_k[0] = hz2_w;
  assign ht_k[0] = ht2_w;
  assign hz_k[1] = hz2_w;
  assign ht_k[1] = ht2_w;
  assign hz_k[2] = hz2_w;
  assign ht_k[2] = ht2_w;
  assign hz_k[3] = hz_w;
  assign ht_k[3] = ht_w;

  for (genvar i = 0; i < mbrk_pkg::NumK; i++) begin : g_k
    mbrk_kstage u_kstage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .idx_i   (2'(i)),
      .hz_i    (hz_k[i]),
      .ht_i    (ht_k[i]),
      .cfg_i   (cfg),
      .valid_i (kv[i]),
      .cell_i  (kc[i]),
      .valid_o (kv[i+1]),
      .cell_o  (kc[i+1])
    );
  end

  logic                sum_valid;
  mbrk_pkg::out_beat_t sum_beat;

  mbrk_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .hz6_i   (hz6_q),
    .ht6_i   (ht6_q),
    .valid_i (kv[mbrk_pkg::NumK]),
    .cell_i  (kc[mbrk_pkg::NumK]),
    .valid_o (sum_valid),
    .beat_o  (sum_beat)
  );

  // output register
  mbrk_pkg::out_beat_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= sum_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_q <= sum_beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

### hw/rtl/mbrk_checker.sv
module mbrk_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input mbrk_pkg::out_beat_t out_beat_o,
  input logic                pready
);

  // a held beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_beat_o))
    else $error("output beat changed while stalled");

  // input side only blocks while a finished beat waits
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input stalled with output free");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while pipe frozen");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind maxwell_bloch_rk4_cell_step_top mbrk_checker u_mbrk_checker (.*);

### verif/maxwell_bloch_rk4_cell_step_top_tb.sv
`timescale 1ns / 100ps

module maxwell_bloch_rk4_cell_step_top_tb;
  import mbrk_pkg::*;

  // wide signed type for the predictor, so no intermediate wraps
  typedef longint signed wide_t;

  localparam wide_t WMAX = 64'sd2147483647;
  localparam wide_t WMIN = -64'sd2147483648;

  // predicted cell result plus the running saturation flag
  class cell_scoreboard;
    out_beat_t pending_q[$];
    bit        sat;
    int        errors;
    wide_t     ht, hz, rn, rp, loss, g;

    function new();
      errors = 0;
    endfunction

    function wide_t clampw(wide_t v);
      if (v > WMAX) begin
        sat = 1;
        return WMAX;
      end
      if (v < WMIN) begin
        sat = 1;
        return WMIN;
      end
      return v;
    endfunction

    function wide_t add(wide_t a, wide_t b);
      return clampw(a + b);
    endfunction

    function wide_t sub(wide_t a, wide_t b);
      return clampw(a - b);
    endfunction

    // exact 128-bit product, rounded half away from zero, then clamped
    function wide_t mul(wide_t a, wide_t b);
      logic [127:0] mag;
      logic [127:0] q;
      logic         neg;
      neg = (a < 0) != (b < 0);
      mag = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
      q   = (mag + (128'd1 << (FracW - 1))) >> FracW;
      if (neg) begin
        if (q > 128'd2147483648) begin
          sat = 1;
          return WMIN;
        end
        return -wide_t'(q[63:0]);
      end
      if (q > 128'd2147483647) begin
        sat = 1;
        return WMAX;
      end
      return wide_t'(q[63:0]);
    endfunction

    function void field_slope(wide_t er, wide_t ei, wide_t pr, wide_t pi, wide_t kr,
                              wide_t ki, output wide_t rr, output wide_t ri);
      rr = sub(mul(g, pi), mul(loss, add(er, kr)));
      ri = sub(mul(g, pr), mul(loss, add(ei, ki)));
    endfunction

    // coupled slopes of inversion and polarization
    function void bloch_slope(wide_t er, wide_t ei, wide_t pr0, wide_t pi0, wide_t nr0,
                              wide_t ni0, wide_t knr, wide_t kni, wide_t kpr, wide_t kpi,
                              output wide_t dnr, output wide_t dni,
                              output wide_t dpr, output wide_t dpi);
      wide_t pr, pi, t, nr, ni, a, b;
      pr  = add(pr0, kpr);
      pi  = add(pi0, kpi);
      t   = add(mul(pr, ei), mul(pi, er));
      dnr = sub(sub(0, add(t, t)), mul(rn, add(nr0, knr)));
      dni = sub(0, mul(rn, add(ni0, kni)));
      nr  = add(nr0, knr);
      ni  = add(ni0, kni);
      a   = sub(mul(er, ni), mul(ei, nr));
      b   = add(mul(er, nr), mul(ei, ni));
      dpr = sub(sub(0, add(a, a)), mul(rp, add(pr0, kpr)));
      dpi = sub(add(b, b), mul(rp, add(pi0, kpi)));
    endfunction

    function wide_t rk_combine(wide_t x, wide_t h6, wide_t k1, wide_t k2, wide_t k3,
                               wide_t k4);
      wide_t s;
      s = add(add(add(k1, add(k2, k2)), add(k3, k3)), k4);
      return add(x, mul(h6, s));
    endfunction

    function void note_cell(in_beat_t c);
      wide_t er, ei, pr, pi, nr, ni, ht2, hz2, ht6, hz6;
      wide_t ke_r[4], ke_i[4], kn_r[4], kn_i[4], kp_r[4], kp_i[4];
      wide_t hs;
      out_beat_t o;
      sat = 0;
      ht2 = (ht + 1) >>> 1;
      hz2 = (hz + 1) >>> 1;
      ht6 = (ht + 3) / 6;
      hz6 = (hz + 3) / 6;
      er = wide_t'(c.field_re);
      ei = wide_t'(c.field_im);
      pr = wide_t'(c.polar_re);
      pi = wide_t'(c.polar_im);
      nr = wide_t'(c.invers_re);
      ni = wide_t'(c.invers_im);
      field_slope(er, ei, pr, pi, 0, 0, ke_r[0], ke_i[0]);
      for (int s = 1; s < 4; s++) begin
        hs = (s == 3) ? hz : hz2;
        field_slope(er, ei, pr, pi, mul(hs, ke_r[s-1]), mul(hs, ke_i[s-1]),
                    ke_r[s], ke_i[s]);
      end
      bloch_slope(er, ei, pr, pi, nr, ni, 0, 0, 0, 0,
                  kn_r[0], kn_i[0], kp_r[0], kp_i[0]);
      for (int s = 1; s < 4; s++) begin
        hs = (s == 3) ? ht : ht2;
        bloch_slope(er, ei, pr, pi, nr, ni,
                    mul(hs, kn_r[s-1]), mul(hs, kn_i[s-1]),
                    mul(hs, kp_r[s-1]), mul(hs, kp_i[s-1]),
                    kn_r[s], kn_i[s], kp_r[s], kp_i[s]);
      end
      // evaluated in the order field, inversion, polarization
      o.next_field_re  = word_t'(rk_combine(er, hz6, ke_r[0], ke_r[1], ke_r[2], ke_r[3]));
      o.next_field_im  = word_t'(rk_combine(ei, hz6, ke_i[0], ke_i[1], ke_i[2], ke_i[3]));
      o.next_invers_re = word_t'(rk_combine(nr, ht6, kn_r[0], kn_r[1], kn_r[2], kn_r[3]));
      o.next_invers_im = word_t'(rk_combine(ni, ht6, kn_i[0], kn_i[1], kn_i[2], kn_i[3]));
      o.next_polar_re  = word_t'(rk_combine(pr, ht6, kp_r[0], kp_r[1], kp_r[2], kp_r[3]));
      o.next_polar_im  = word_t'(rk_combine(pi, ht6, kp_i[0], kp_i[1], kp_i[2], kp_i[3]));
      o.saturated = sat;
      pending_q.push_back(o);
    endfunction

    function void check_cell(out_beat_t got);
      out_beat_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.next_field_re !== want.next_field_re)
        report("next_field_re", want.next_field_re, got.next_field_re);
      if (got.next_field_im !== want.next_field_im)
        report("next_field_im", want.next_field_im, got.next_field_im);
      if (got.next_polar_re !== want.next_polar_re)
        report("next_polar_re", want.next_polar_re, got.next_polar_re);
      if (got.next_polar_im !== want.next_polar_im)
        report("next_polar_im", want.next_polar_im, got.next_polar_im);
      if (got.next_invers_re !== want.next_invers_re)
        report("next_invers_re", want.next_invers_re, got.next_invers_re);
      if (got.next_invers_im !== want.next_invers_im)
        report("next_invers_im", want.next_invers_im, got.next_invers_im);
      if (got.saturated !== want.saturated)
        report("saturated", 32'(want.saturated), 32'(got.saturated));
    endfunction

    function void report(string fld, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s expected %h actual %h", $time, fld, want, got);
      errors++;
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_beat_t  in_beat_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_beat_t out_beat_o;
  logic      psel = 1'b0;
  logic      penable = 1'b0;
  logic      pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  cell_scoreboard sb = new();

  // idle percentages of the current phase
  int send_idle = 0;
  int recv_stall = 0;

  maxwell_bloch_rk4_cell_step_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_beat_i,
    .out_valid_o, .out_ready_i, .out_beat_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result side: sample at rising edge, pick ready at falling edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_cell(out_beat_o);
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall);
  end

  // apb write: setup then access, register takes it on the access edge
  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= 5'(4 * idx);
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegTimeStep:  sb.ht   = wide_t'(val[30:0]);
      RegSpaceStep: sb.hz   = wide_t'(val[30:0]);
      RegInvDecay:  sb.rn   = wide_t'(val[30:0]);
      RegPolDecay:  sb.rp   = wide_t'(val[30:0]);
      RegFieldLoss: sb.loss = wide_t'(val[30:0]);
      RegGain:      sb.g    = wide_t'(signed'(val));
      default: ;
    endcase
  endtask

  task automatic set_coeffs(logic [31:0] ht, logic [31:0] hz, logic [31:0] rn,
                            logic [31:0] rp, logic [31:0] loss, logic [31:0] g);
    write_reg(RegTimeStep, ht);
    write_reg(RegSpaceStep, hz);
    write_reg(RegInvDecay, rn);
    write_reg(RegPolDecay, rp);
    write_reg(RegFieldLoss, loss);
    write_reg(RegGain, g);
    // h/6 is registered in the cycle after the write
    repeat (2) @(negedge clk_i);
  endtask

  // one input beat; valid held until taken, random gap before it
  task automatic send_cell(in_beat_t c);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_cell(c);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(5))
      0: return MaxW;
      1: return MinW;
      2: return word_t'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      3: return word_t'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
      default: return word_t'($urandom());
    endcase
  endfunction

  // mostly physical magnitudes so the runge-kutta path is exercised unsaturated
  function automatic in_beat_t rand_cell();
    in_beat_t c;
    if ($urandom_range(99) < 70) begin
      c.field_re  = word_t'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      c.field_im  = word_t'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      c.polar_re  = word_t'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      c.polar_im  = word_t'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      c.invers_re = word_t'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      c.invers_im = word_t'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    end else begin
      c = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
    end
    return c;
  endfunction

  function automatic logic [31:0] rand_rate();
    case ($urandom_range(3))
      0: return 32'(1 << 24) >> $urandom_range(0, 12);
      1: return $urandom_range(0, 32'h0100_0000);
      default: return 32'($urandom()) & 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    return ($urandom_range(1)) ? 32'($urandom()) :
           32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
  endfunction

  initial begin
    in_beat_t c;
    sb.ht = 16777216; sb.hz = 16777; sb.rn = 17; sb.rp = 17; sb.loss = 0; sb.g = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset coefficients first, then extremes
    send_cell('0);
    send_cell({6{MaxW}});
    send_cell({6{MinW}});
    send_cell({MaxW, MinW, MaxW, MinW, MaxW, MinW});
    send_cell({32'sh0100_0000, 32'sh0, 32'sh0080_0000, -32'sh0080_0000,
               32'sh0100_0000, -32'sh0040_0000});
    send_cell({6{32'shFFFF_FFFF}});
    drain();

    // zero steps and rates pass everything through
    set_coeffs(0, 0, 0, 0, 0, 0);
    send_cell({MaxW, MinW, 32'sh1234_5678, -32'sh1234_5678, 32'sh0100_0000, 32'sh1});
    send_cell(rand_cell());
    drain();

    // largest coefficients push nonzero cells into saturation
    set_coeffs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_cell({6{32'sh0100_0000}});
    send_cell('0);
    send_cell({6{MinW}});
    drain();
    set_coeffs(32'h0100_0000, 32'h0080_0000, 32'h0010_0000, 32'h0020_0000,
               32'h0008_0000, 32'h8000_0000);
    send_cell({6{-32'sh0100_0000}});
    send_cell({32'sh0040_0000, -32'sh0080_0000, 32'sh0020_0000,
               32'sh0030_0000, -32'sh0100_0000, 32'sh0070_0000});
    send_cell({6{MaxW}});
    // hold off until every expected result is back
    drain();

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 57; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 57; end
        default: begin send_idle = 25; recv_stall = 25; end
      endcase
      set_coeffs(rand_rate(), rand_rate(), rand_rate(), rand_rate(), rand_rate(),
                 rand_gain());
      for (int i = 0; i < 86; i++) begin
        c = rand_cell();
        send_cell(c);
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### maxwell_bloch_rk4_cell_step_top.f
hw/rtl/mbrk_pkg.sv
hw/rtl/mbrk_kstage.sv
hw/rtl/mbrk_sum.sv
hw/rtl/maxwell_bloch_rk4_cell_step_top.sv
hw/rtl/mbrk_checker.sv
verif/maxwell_bloch_rk4_cell_step_top_tb.sv
